// ===== rtl/smg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smg_pkg
// Shared types and constants of the splitmix64 generator: command codes,
// mixer constants, sequencer states and an xorshift helper function.
// ----------------------------------------------------------------------------
package smg_pkg;

  // command codes carried by the input transaction
  typedef enum logic [1:0] {
    CMD_NEXT   = 2'd0,
    CMD_SPLIT  = 2'd1,
    CMD_RESEED = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  // generator constants
  localparam logic [63:0] GAMMA_INIT   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] M64_K1       = 64'hff51afd7ed558ccd;
  localparam logic [63:0] M64_K2       = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] M13_K1       = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] M13_K2       = 64'h94d049bb133111eb;
  localparam logic [63:0] ALT_BITS     = 64'haaaaaaaaaaaaaaaa;
  localparam logic [6:0]  MIN_TRANS    = 7'd24;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRE   = 6'b000010,
    S_WAIT1 = 6'b000100,
    S_WAIT2 = 6'b001000,
    S_GFIX  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // xor with a right-shifted copy of itself
  function automatic logic [63:0] xorshift(input logic [63:0] w, input int unsigned n);
    xorshift = w ^ (w >> n);
  endfunction

endpackage

// ===== rtl/smg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smg_in_if / smg_out_if
// Valid/ready channels of the splitmix64 generator, one for the command
// transactions and one for the result transactions.
// ----------------------------------------------------------------------------
interface smg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] seed_in;
  logic [63:0] gamma_in;

  modport source (output valid, command, seed_in, gamma_in, input ready);
  modport sink   (input valid, command, seed_in, gamma_in, output ready);
endinterface

interface smg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic [52:0] unit_fraction;
  logic [63:0] child_seed;
  logic [63:0] child_gamma;

  modport source (output valid, word, unit_fraction, child_seed, child_gamma, input ready);
  modport sink   (input valid, word, unit_fraction, child_seed, child_gamma, output ready);
endinterface

// ===== rtl/splitmix64_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix64_generator_top
// SplitMix64 generator with next, split, reseed and load commands.
// ----------------------------------------------------------------------------
// One command at a time: in_ch.ready is high only while the block is idle,
// and each command returns exactly one result transaction on out_ch. All
// 64-bit multiplies run on one shared 32 x 32 multiplier. Each mixer needs a
// launch state and two dependent multiplies. A load goes straight to the
// result, a next takes one mix, and a split or reseed takes two mixes plus
// the gamma fix-up state. The next command can be taken the cycle after the
// result transaction, so receiver stalls delay it. After reset the seed is
// zero and the gamma is the golden gamma; no clearing pass is needed.
module splitmix64_generator_top (
  input  logic      clk,
  input  logic      rst_n,
  smg_in_if.sink    in_ch,
  smg_out_if.source out_ch
);

  smg_pkg::state_t state_r;
  smg_pkg::cmd_t   cmd_r;
  logic            pass_r;
  logic [63:0]     seed_r;
  logic [63:0]     gamma_r;
  logic [63:0]     z_r;
  logic [63:0]     op2_r;
  logic [63:0]     g_r;
  logic [63:0]     word_r;
  logic [63:0]     cseed_r;
  logic [63:0]     cgamma_r;

  logic            accept;
  logic [63:0]     adv;
  logic            mul_start;
  logic [63:0]     mul_a;
  logic [63:0]     mul_b;
  logic            mul_done;
  logic [63:0]     mul_p;
  logic [63:0]     sx_first;
  logic [63:0]     sx_mid;
  logic [63:0]     mix_out;
  logic [6:0]      trans_cnt;
  logic [63:0]     gfix;

  assign accept = in_ch.valid && in_ch.ready;
  assign adv    = seed_r + gamma_r;

  // mixer shift stages, mix64 on the first pass and the variant-13 mix on the second
  assign sx_first = pass_r ? smg_pkg::xorshift(z_r, 30)   : smg_pkg::xorshift(z_r, 33);
  assign sx_mid   = pass_r ? smg_pkg::xorshift(mul_p, 27) : smg_pkg::xorshift(mul_p, 33);
  assign mix_out  = pass_r ? smg_pkg::xorshift(mul_p, 31) : smg_pkg::xorshift(mul_p, 33);

  // multiplier launch
  assign mul_start = (state_r == smg_pkg::S_PRE) || ((state_r == smg_pkg::S_WAIT1) && mul_done);
  assign mul_a     = (state_r == smg_pkg::S_PRE) ? sx_first : sx_mid;
  always_comb begin
    if (state_r == smg_pkg::S_PRE) begin
      mul_b = pass_r ? smg_pkg::M13_K1 : smg_pkg::M64_K1;
    end else begin
      mul_b = pass_r ? smg_pkg::M13_K2 : smg_pkg::M64_K2;
    end
  end

  smg_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // gamma fix-up: too few bit transitions gets the alternating pattern
  assign trans_cnt = 7'($countones(g_r ^ (g_r >> 1)));
  assign gfix      = ((trans_cnt < smg_pkg::MIN_TRANS) ? (g_r ^ smg_pkg::ALT_BITS) : g_r)
                     | 64'd1;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smg_pkg::S_IDLE;
      pass_r  <= 1'b0;
      seed_r  <= 64'd0;
      gamma_r <= smg_pkg::GAMMA_INIT;
    end else begin
      unique case (state_r)
        smg_pkg::S_IDLE: begin
          if (accept) begin
            pass_r <= 1'b0;
            unique case (smg_pkg::cmd_t'(in_ch.command))
              smg_pkg::CMD_NEXT, smg_pkg::CMD_SPLIT: begin
                seed_r  <= adv;
                state_r <= smg_pkg::S_PRE;
              end
              smg_pkg::CMD_RESEED: begin
                state_r <= smg_pkg::S_PRE;
              end
              smg_pkg::CMD_LOAD: begin
                seed_r  <= in_ch.seed_in;
                gamma_r <= in_ch.gamma_in | 64'd1;
                state_r <= smg_pkg::S_OUT;
              end
            endcase
          end
        end
        smg_pkg::S_PRE: begin
          state_r <= smg_pkg::S_WAIT1;
        end
        smg_pkg::S_WAIT1: begin
          if (mul_done) begin
            state_r <= smg_pkg::S_WAIT2;
          end
        end
        smg_pkg::S_WAIT2: begin
          if (mul_done) begin
            if (pass_r) begin
              state_r <= smg_pkg::S_GFIX;
            end else begin
              unique case (cmd_r)
                smg_pkg::CMD_SPLIT: begin
                  seed_r  <= adv;
                  pass_r  <= 1'b1;
                  state_r <= smg_pkg::S_PRE;
                end
                smg_pkg::CMD_RESEED: begin
                  seed_r  <= mix_out;
                  pass_r  <= 1'b1;
                  state_r <= smg_pkg::S_PRE;
                end
                smg_pkg::CMD_NEXT, smg_pkg::CMD_LOAD: begin
                  state_r <= smg_pkg::S_OUT;
                end
              endcase
            end
          end
        end
        smg_pkg::S_GFIX: begin
          if (cmd_r == smg_pkg::CMD_RESEED) begin
            gamma_r <= gfix;
          end
          state_r <= smg_pkg::S_OUT;
        end
        smg_pkg::S_OUT: begin
          if (out_ch.ready) begin
            state_r <= smg_pkg::S_IDLE;
          end
        end
      endcase
    end
  end

  // working values and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= smg_pkg::cmd_t'(in_ch.command);
      word_r   <= 64'd0;
      cseed_r  <= 64'd0;
      cgamma_r <= 64'd0;
      op2_r    <= in_ch.seed_in + smg_pkg::GAMMA_INIT;
      if (smg_pkg::cmd_t'(in_ch.command) == smg_pkg::CMD_RESEED) begin
        z_r <= in_ch.seed_in;
      end else begin
        z_r <= adv;
      end
    end
    if ((state_r == smg_pkg::S_WAIT2) && mul_done) begin
      if (pass_r) begin
        g_r <= mix_out | 64'd1;
      end else begin
        unique case (cmd_r)
          smg_pkg::CMD_NEXT:   word_r <= mix_out;
          smg_pkg::CMD_SPLIT: begin
            cseed_r <= mix_out;
            z_r     <= adv;
          end
          smg_pkg::CMD_RESEED: z_r <= op2_r;
          smg_pkg::CMD_LOAD:   word_r <= 64'd0;
        endcase
      end
    end
    if ((state_r == smg_pkg::S_GFIX) && (cmd_r == smg_pkg::CMD_SPLIT)) begin
      cgamma_r <= gfix;
    end
  end

  // channel outputs
  assign in_ch.ready          = (state_r == smg_pkg::S_IDLE);
  assign out_ch.valid         = (state_r == smg_pkg::S_OUT);
  assign out_ch.word          = word_r;
  assign out_ch.unit_fraction = word_r[63:11];
  assign out_ch.child_seed    = cseed_r;
  assign out_ch.child_gamma   = cgamma_r;

endmodule

// ===== rtl/smg_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smg_mul64
// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial
// products on one shared multiplier.
// ----------------------------------------------------------------------------
module smg_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc_r;
  logic [1:0]  step_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  // operand select: low x low, then the two cross terms
  always_comb begin
    case (step_r)
      2'd0: begin
        ma = a_r[31:0];
        mb = b_r[31:0];
      end
      2'd1: begin
        ma = a_r[63:32];
        mb = b_r[31:0];
      end
      default: begin
        ma = a_r[31:0];
        mb = b_r[63:32];
      end
    endcase
  end

  // single 32 x 32 multiplier, full 64-bit product
  assign prod = 64'(ma) * 64'(mb);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= 2'd0;
      end else if (run_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (run_r) begin
      if (step_r == 2'd0) begin
        acc_r <= prod;
      end else begin
        acc_r <= acc_r + {prod[31:0], 32'd0};
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the splitmix64 generator. A behavioral copy of the
// generator state predicts the result of every accepted command; a monitor
// compares each result transaction field by field, in order. Directed
// commands come first, then random traffic under several idle and stall
// mixes, a long receiver hold-off and a sender pause until drained.
// ----------------------------------------------------------------------------
module testbench;

  // generator constants, kept apart from the design's own copies
  localparam logic [63:0] SEED_STEP   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FMIX_K1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_K2     = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] VAR13_K1    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] VAR13_K2    = 64'h94d049bb133111eb;
  localparam logic [63:0] ALT_PATTERN = 64'haaaaaaaaaaaaaaaa;
  localparam int          MIN_FLIPS   = 24;

  localparam int CLK_HALF   = 6;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 40;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic [63:0] word;
    logic [52:0] unit_fraction;
    logic [63:0] child_seed;
    logic [63:0] child_gamma;
  } draw_t;

  logic clk;
  logic rst_n;

  smg_in_if  in_ch ();
  smg_out_if out_ch ();

  splitmix64_generator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted generator state and the draws still owed by the block
  logic [63:0] model_seed;
  logic [63:0] model_gamma;
  draw_t       pending_draws[$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- mixers

  // murmur-style finalizer
  function automatic logic [63:0] fmix64(input logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 33)) * FMIX_K1;
    t = (t ^ (t >> 33)) * FMIX_K2;
    return t ^ (t >> 33);
  endfunction

  // variant-13 mixer, forced odd, with the low-transition fix-up
  function automatic logic [63:0] odd_gamma(input logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 30)) * VAR13_K1;
    t = (t ^ (t >> 27)) * VAR13_K2;
    t = (t ^ (t >> 31)) | 64'd1;
    if ($countones(t ^ (t >> 1)) < MIN_FLIPS) t = t ^ ALT_PATTERN;
    return t;
  endfunction

  // apply one command to the predicted state, return the expected draw
  function automatic draw_t advance_generator(input smg_pkg::cmd_t cmd,
                                              input logic [63:0] seed_arg,
                                              input logic [63:0] gamma_arg);
    draw_t       d;
    logic [63:0] first_seed;
    d = '0;
    case (cmd)
      smg_pkg::CMD_NEXT: begin
        model_seed      = model_seed + model_gamma;
        d.word          = fmix64(model_seed);
        d.unit_fraction = d.word[63:11];
      end
      smg_pkg::CMD_SPLIT: begin
        first_seed    = model_seed + model_gamma;
        model_seed    = first_seed + model_gamma;
        d.child_seed  = fmix64(first_seed);
        d.child_gamma = odd_gamma(model_seed) | 64'd1;
      end
      smg_pkg::CMD_RESEED: begin
        model_seed  = fmix64(seed_arg);
        model_gamma = odd_gamma(seed_arg + SEED_STEP) | 64'd1;
      end
      default: begin
        model_seed  = seed_arg;
        model_gamma = gamma_arg | 64'd1;
      end
    endcase
    return d;
  endfunction

  // random 64-bit operand with a bias toward edge values
  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic smg_pkg::cmd_t rand_cmd();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return smg_pkg::CMD_NEXT;
    if (pick < 65) return smg_pkg::CMD_SPLIT;
    if (pick < 82) return smg_pkg::CMD_RESEED;
    return smg_pkg::CMD_LOAD;
  endfunction

  // ---------------------------------------------------------------- driver

  // offer one command transaction, return at the edge that accepts it
  task automatic send_command(input smg_pkg::cmd_t cmd, input logic [63:0] seed_arg,
                              input logic [63:0] gamma_arg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.seed_in  <= seed_arg;
    in_ch.gamma_in <= gamma_arg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_draws.push_back(advance_generator(cmd, seed_arg, gamma_arg));
  endtask

  // stop offering and wait until every predicted draw has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  // ready pattern, with long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      if (error_count <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    end
  endtask

  // compare every result transaction with the oldest prediction
  initial begin
    draw_t d;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_draws.size() == 0) begin
          error_count++;
          if (error_count <= SHOW_LIMIT)
            $display("%0t: result transaction with no command outstanding", $time);
        end else begin
          d = pending_draws.pop_front();
          check_field("word", d.word, out_ch.word);
          check_field("unit_fraction", {11'd0, d.unit_fraction}, {11'd0, out_ch.unit_fraction});
          check_field("child_seed", d.child_seed, out_ch.child_seed);
          check_field("child_gamma", d.child_gamma, out_ch.child_gamma);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // edge operands, every command, wraparound and forced-odd gamma
  task automatic test_directed();
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_SPLIT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    // even gamma of zero is forced to one
    send_command(smg_pkg::CMD_LOAD, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_SPLIT, 64'd0, 64'd0);
    // seed and gamma at all ones, advances wrap around
    send_command(smg_pkg::CMD_LOAD, '1, '1);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_SPLIT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_RESEED, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    // seed plus golden gamma wraps
    send_command(smg_pkg::CMD_RESEED, '1, '1);
    send_command(smg_pkg::CMD_SPLIT, 64'd0, 64'd0);
    send_command(smg_pkg::CMD_LOAD, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5554);
    send_command(smg_pkg::CMD_SPLIT, '1, '1);
    // seed plus golden gamma is exactly zero
    send_command(smg_pkg::CMD_RESEED, 64'h61c8_8646_80b5_83eb, 64'd0);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
    // operands are ignored by next
    send_command(smg_pkg::CMD_NEXT, '1, '1);
    // back to the reset state
    send_command(smg_pkg::CMD_LOAD, 64'd0, SEED_STEP);
    send_command(smg_pkg::CMD_NEXT, 64'd0, 64'd0);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_command(rand_cmd(), rand_word(), rand_word());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_receiver_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (8) send_command(rand_cmd(), rand_word(), rand_word());
  endtask

  // sender pauses until every draw is back, then resumes
  task automatic test_sender_pause();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    repeat (5) send_command(rand_cmd(), rand_word(), rand_word());
    wait_drained();
    repeat (5) send_command(rand_cmd(), rand_word(), rand_word());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= smg_pkg::CMD_NEXT;
    in_ch.seed_in  <= 64'd0;
    in_ch.gamma_in <= 64'd0;
    model_seed  = 64'd0;
    model_gamma = SEED_STEP;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(210, 0, 0);
    test_random_traffic(210, 71, 0);
    test_receiver_hold();
    test_random_traffic(210, 0, 71);
    test_sender_pause();
    test_random_traffic(210, 23, 23);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0 && pending_draws.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
